// ===== src/ars_pkg.sv =====
// ----------------------------------------------------------------------------
// ars_pkg
// Types, codes and helpers shared by the alignment record statistics block.
// ----------------------------------------------------------------------------
package ars_pkg;

    localparam longint unsigned ARS_MAX_READ_LENGTH = 64'd65535;

    // item kinds
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_CIGAR  = 2'd1;
    localparam logic [1:0] OP_SEQ    = 2'd2;

    // cigar operations that are counted
    localparam logic [3:0] CIG_INS = 4'd1;
    localparam logic [3:0] CIG_DEL = 4'd2;

    // base nibble codes
    localparam logic [3:0] BASE_A = 4'd1;
    localparam logic [3:0] BASE_C = 4'd2;
    localparam logic [3:0] BASE_G = 4'd4;
    localparam logic [3:0] BASE_T = 4'd8;
    localparam logic [3:0] BASE_N = 4'd15;

    localparam int NUM_BASES = 5;

    // record flag bit positions
    localparam int FL_PAIRED    = 0;
    localparam int FL_PROPER    = 1;
    localparam int FL_UNMAP     = 2;
    localparam int FL_MUNMAP    = 3;
    localparam int FL_REVERSE   = 4;
    localparam int FL_READ1     = 6;
    localparam int FL_SECONDARY = 8;

    // status bit positions
    localparam int ST_MAPPED  = 0;
    localparam int ST_REVERSE = 1;
    localparam int ST_PRIMARY = 2;
    localparam int ST_MATE1   = 3;
    localparam int ST_MATE2   = 4;
    localparam int ST_SINGLE  = 5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        flags;
        logic [7:0]         map_quality_in;
        logic signed [31:0] template_length;
        logic [15:0]        edit_distance_in;
        logic [15:0]        read_length_in;
        logic [31:0]        cigar_word;
        logic [7:0]         seq_byte;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  status_bits;
        logic [15:0] edit_distance;
        logic [15:0] indel_count;
        logic [31:0] indel_length;
        logic [7:0]  map_quality;
        logic [31:0] insert_size;
        logic [15:0] read_length;
        logic [15:0] count_a;
        logic [15:0] count_c;
        logic [15:0] count_g;
        logic [15:0] count_t;
        logic [15:0] count_n;
    } t_out_item;

    // decoded header, all zero for an unmapped record
    typedef struct packed {
        logic [5:0]  status_bits;
        logic [15:0] edit_distance;
        logic [7:0]  map_quality;
        logic [31:0] insert_size;
        logic [15:0] read_length;
    } t_hdr_info;

    // one-hot counter slot of a base code, zero for codes that are not counted
    function automatic logic [NUM_BASES-1:0] base_slot(input logic [3:0] code);
        logic [NUM_BASES-1:0] s;
        s = '0;
        unique case (code)
            BASE_A:  s = 5'b00001;
            BASE_C:  s = 5'b00010;
            BASE_G:  s = 5'b00100;
            BASE_T:  s = 5'b01000;
            BASE_N:  s = 5'b10000;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {15'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ===== src/ars_in_reg.sv =====
// ----------------------------------------------------------------------------
// ars_in_reg
// Input register: captures one item per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module ars_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_valid,
    input  ars_pkg::t_in_item i_item,
    output logic              o_valid,
    output ars_pkg::t_in_item o_item
);
    import ars_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/ars_hdr_dec.sv =====
// ----------------------------------------------------------------------------
// ars_hdr_dec
// Header decode: flag bits to status, absolute insert size, held fields.
// ----------------------------------------------------------------------------
module ars_hdr_dec (
    input  ars_pkg::t_in_item  i_item,
    output ars_pkg::t_hdr_info o_hdr
);
    import ars_pkg::*;

    logic [15:0] fl;
    logic [31:0] tlen;
    logic [31:0] tlen_abs;

    assign fl       = i_item.flags;
    assign tlen     = i_item.template_length;
    assign tlen_abs = tlen[31] ? (32'd0 - tlen) : tlen;

    always_comb begin
        o_hdr = '0;
        if (!fl[FL_UNMAP]) begin
            o_hdr.status_bits[ST_MAPPED]  = 1'b1;
            o_hdr.status_bits[ST_REVERSE] = fl[FL_REVERSE];
            o_hdr.status_bits[ST_PRIMARY] = !fl[FL_SECONDARY];
            o_hdr.status_bits[ST_MATE1]   = fl[FL_PAIRED] && fl[FL_READ1];
            o_hdr.status_bits[ST_MATE2]   = fl[FL_PAIRED] && !fl[FL_READ1];
            o_hdr.status_bits[ST_SINGLE]  = !fl[FL_PAIRED];
            if (fl[FL_PAIRED] && fl[FL_PROPER] && !fl[FL_MUNMAP]) begin
                o_hdr.insert_size = tlen_abs;
            end
            o_hdr.map_quality   = i_item.map_quality_in;
            o_hdr.edit_distance = i_item.edit_distance_in;
            o_hdr.read_length   = i_item.read_length_in;
        end
    end

endmodule

// ===== src/ars_accum.sv =====
// ----------------------------------------------------------------------------
// ars_accum
// Record state, indel and base counters, and the result register.
// ----------------------------------------------------------------------------
module ars_accum #(
    parameter int unsigned      BL_W   = 16,
    parameter logic [BL_W-1:0]  BL_LIM = '1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_valid,
    input  ars_pkg::t_in_item  i_item,
    input  ars_pkg::t_hdr_info i_hdr,
    output logic               o_valid,
    output ars_pkg::t_out_item o_item
);
    import ars_pkg::*;

    logic [5:0]       r_status,   n_status;
    logic [15:0]      r_edit,     n_edit;
    logic [7:0]       r_qual,     n_qual;
    logic [31:0]      r_insert,   n_insert;
    logic [BL_W-1:0]  r_left,     n_left;
    logic [15:0]      r_rlen,     n_rlen;
    logic [15:0]      r_icnt,     n_icnt;
    logic [31:0]      r_ilen,     n_ilen;
    logic [15:0]      r_cnt [NUM_BASES];
    logic [15:0]      n_cnt [NUM_BASES];
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic                 mapped;
    logic [3:0]           cig_op;
    logic [32:0]          len_sum;
    logic                 hi_ok;
    logic                 lo_ok;
    logic [NUM_BASES-1:0] hi_slot;
    logic [NUM_BASES-1:0] lo_slot;
    logic [BL_W-1:0]      hdr_left;
    logic                 emit;

    assign mapped  = r_status[ST_MAPPED];
    assign cig_op  = i_item.cigar_word[3:0];
    assign len_sum = {1'b0, r_ilen} + {5'd0, i_item.cigar_word[31:4]};
    assign hi_ok   = (r_left != '0);
    assign lo_ok   = (r_left >= BL_W'(2));
    assign hi_slot = base_slot(i_item.seq_byte[7:4]);
    assign lo_slot = base_slot(i_item.seq_byte[3:0]);
    assign hdr_left = (i_hdr.read_length < 16'(BL_LIM)) ? BL_W'(i_hdr.read_length) : BL_LIM;
    assign emit    = i_advance && i_valid && i_item.last;

    always_comb begin
        n_status = r_status;
        n_edit   = r_edit;
        n_qual   = r_qual;
        n_insert = r_insert;
        n_left   = r_left;
        n_rlen   = r_rlen;
        n_icnt   = r_icnt;
        n_ilen   = r_ilen;
        for (int k = 0; k < NUM_BASES; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        if (i_item.opcode == OP_HEADER) begin
            n_status = i_hdr.status_bits;
            n_edit   = i_hdr.edit_distance;
            n_qual   = i_hdr.map_quality;
            n_insert = i_hdr.insert_size;
            n_rlen   = i_hdr.read_length;
            n_left   = hdr_left;
            n_icnt   = '0;
            n_ilen   = '0;
            for (int k = 0; k < NUM_BASES; k++) begin
                n_cnt[k] = '0;
            end
        end else if (mapped && i_item.opcode == OP_CIGAR) begin
            if (cig_op == CIG_INS || cig_op == CIG_DEL) begin
                n_icnt = sat_add16(r_icnt, 2'd1);
                n_ilen = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
            end
        end else if (mapped && i_item.opcode == OP_SEQ) begin
            // both nibbles can land in the same counter
            for (int k = 0; k < NUM_BASES; k++) begin
                n_cnt[k] = sat_add16(r_cnt[k],
                    {1'b0, hi_ok && hi_slot[k]} + {1'b0, lo_ok && lo_slot[k]});
            end
            n_left = lo_ok ? (r_left - BL_W'(2)) : '0;
        end
    end

    always_comb begin
        n_out.status_bits   = n_status;
        n_out.edit_distance = n_edit;
        n_out.indel_count   = n_icnt;
        n_out.indel_length  = n_ilen;
        n_out.map_quality   = n_qual;
        n_out.insert_size   = n_insert;
        n_out.read_length   = n_rlen;
        n_out.count_a       = n_cnt[0];
        n_out.count_c       = n_cnt[1];
        n_out.count_g       = n_cnt[2];
        n_out.count_t       = n_cnt[3];
        n_out.count_n       = n_cnt[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_edit   <= '0;
            r_qual   <= '0;
            r_insert <= '0;
            r_left   <= '0;
            r_rlen   <= '0;
            r_icnt   <= '0;
            r_ilen   <= '0;
            for (int k = 0; k < NUM_BASES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (emit) begin
            // record closes: state back to its reset values
            r_status <= '0;
            r_edit   <= '0;
            r_qual   <= '0;
            r_insert <= '0;
            r_left   <= '0;
            r_rlen   <= '0;
            r_icnt   <= '0;
            r_ilen   <= '0;
            for (int k = 0; k < NUM_BASES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_advance && i_valid) begin
            r_status <= n_status;
            r_edit   <= n_edit;
            r_qual   <= n_qual;
            r_insert <= n_insert;
            r_left   <= n_left;
            r_rlen   <= n_rlen;
            r_icnt   <= n_icnt;
            r_ilen   <= n_ilen;
            for (int k = 0; k < NUM_BASES; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= i_valid && i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== src/alignment_record_stats.sv =====
// ----------------------------------------------------------------------------
// alignment_record_stats
// Per-record statistics over a stream of header, cigar and sequence items.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless the input stalls: an item goes into the
// input register, then the record state and the result register are updated
// from it when the pipeline advances. The only thing
// that holds the input back is a result that waits in the output register
// while the consumer stalls; then the input stalls in the same cycle.
// Counters saturate; GC is count_c plus count_g. No clearing pass is needed.
module alignment_record_stats #(
    parameter longint unsigned MAX_READ_LENGTH = ars_pkg::ARS_MAX_READ_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ars_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ars_pkg::t_out_item o_out_data
);
    import ars_pkg::*;

    localparam longint unsigned LEFT_LIM = (MAX_READ_LENGTH > 64'd65535) ? 64'd65535
                                                                         : MAX_READ_LENGTH;
    localparam int unsigned     BL_W     = $clog2(LEFT_LIM + 64'd1);
    localparam logic [BL_W-1:0] BL_LIM   = BL_W'(LEFT_LIM);

    logic      advance;
    logic      stg_valid;
    t_in_item  stg_item;
    t_hdr_info stg_hdr;

    assign advance    = !o_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    ars_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (i_in_valid),
        .i_item    (i_in_data),
        .o_valid   (stg_valid),
        .o_item    (stg_item)
    );

    ars_hdr_dec u_hdr_dec (
        .i_item (stg_item),
        .o_hdr  (stg_hdr)
    );

    ars_accum #(
        .BL_W   (BL_W),
        .BL_LIM (BL_LIM)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (stg_valid),
        .i_item    (stg_item),
        .i_hdr     (stg_hdr),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data)
    );

endmodule

// ===== src/ars_checker.sv =====
// ----------------------------------------------------------------------------
// ars_checker
// Port-level checks of the statistics block, bound to its top level.
// ----------------------------------------------------------------------------
module ars_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ars_pkg::t_out_item o_out_data
);
    import ars_pkg::*;

    // a waiting result holds until the transaction completes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // input stalls only behind a blocked result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // unmapped record reports nothing but zeros
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.status_bits[ST_MAPPED] |-> o_out_data == '0)
        else $error("unmapped record with nonzero fields");

    // mate1, mate2 and single end exclude each other
    a_mate_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_data.status_bits[ST_SINGLE:ST_MATE1]))
        else $error("conflicting pairing status");

    // insert size only for paired reads
    a_insert_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.insert_size != '0 |->
            !o_out_data.status_bits[ST_SINGLE] && o_out_data.status_bits[ST_MAPPED])
        else $error("insert size on an unpaired record");

endmodule

bind alignment_record_stats ars_checker u_ars_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== dv/alignment_record_stats_tb.sv =====
// ----------------------------------------------------------------------------
// alignment_record_stats_tb
// Self-checking bench for the alignment record statistics block. A table of
// hand-built records covers empty, unmapped, restarted and truncated records
// and the field extremes. Random records follow, mostly well formed with some
// broken ones mixed in. One record of long indels saturates the indel length.
// Every result is checked field by field against the record state predictor
// or a typed-in result, under three mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module alignment_record_stats_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ars_pkg::*;

    // opcode three is a no-op item
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [15:0] FM_PAIRED    = 16'h1 << FL_PAIRED;
    localparam logic [15:0] FM_PROPER    = 16'h1 << FL_PROPER;
    localparam logic [15:0] FM_UNMAP     = 16'h1 << FL_UNMAP;
    localparam logic [15:0] FM_MUNMAP    = 16'h1 << FL_MUNMAP;
    localparam logic [15:0] FM_REVERSE   = 16'h1 << FL_REVERSE;
    localparam logic [15:0] FM_READ1     = 16'h1 << FL_READ1;
    localparam logic [15:0] FM_SECONDARY = 16'h1 << FL_SECONDARY;

    localparam int PHASE_ITEMS = 210;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // shadow of the driven item: a typed-in result, if any
    bit        drv_typed = 1'b0;
    t_out_item drv_want = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int mismatch_count = 0;

    // predicted record state
    logic [5:0]  rec_status;
    logic [15:0] rec_edit;
    logic [7:0]  rec_quality;
    logic [31:0] rec_insert;
    logic [15:0] rec_bases_left;
    logic [15:0] rec_read_len;
    logic [15:0] rec_indels;
    logic [31:0] rec_indel_len;
    logic [15:0] rec_bases [NUM_BASES];

    t_out_item expected_stats [$];
    t_row      directed_rows [$];

    alignment_record_stats i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic clear_record();
        rec_status     = '0;
        rec_edit       = '0;
        rec_quality    = '0;
        rec_insert     = '0;
        rec_bases_left = '0;
        rec_read_len   = '0;
        rec_indels     = '0;
        rec_indel_len  = '0;
        for (int k = 0; k < NUM_BASES; k++) rec_bases[k] = '0;
    endtask

    task automatic count_nibble(input logic [3:0] code);
        int slot;
        if (rec_bases_left != 0) begin
            rec_bases_left--;
            case (code)
                BASE_A:  slot = 0;
                BASE_C:  slot = 1;
                BASE_G:  slot = 2;
                BASE_T:  slot = 3;
                BASE_N:  slot = 4;
                default: slot = -1;
            endcase
            if (slot >= 0 && rec_bases[slot] != 16'hFFFF) rec_bases[slot]++;
        end
    endtask

    task automatic predict_stats(input t_in_item it, output bit emits, output t_out_item res);
        logic [15:0] fl;
        logic [31:0] tl_bits;
        logic [27:0] seg_len;
        logic [32:0] sum;
        emits = 1'b0;
        res = '0;
        case (it.opcode)
            OP_HEADER: begin
                clear_record();
                fl = it.flags;
                if (!fl[FL_UNMAP]) begin
                    rec_status[ST_MAPPED]  = 1'b1;
                    rec_status[ST_REVERSE] = fl[FL_REVERSE];
                    rec_status[ST_PRIMARY] = !fl[FL_SECONDARY];
                    if (fl[FL_PAIRED]) begin
                        rec_status[ST_MATE1] = fl[FL_READ1];
                        rec_status[ST_MATE2] = !fl[FL_READ1];
                        if (fl[FL_PROPER] && !fl[FL_MUNMAP]) begin
                            tl_bits = it.template_length;
                            rec_insert = tl_bits[31] ? 32'd0 - tl_bits : tl_bits;
                        end
                    end else begin
                        rec_status[ST_SINGLE] = 1'b1;
                    end
                    rec_quality  = it.map_quality_in;
                    rec_edit     = it.edit_distance_in;
                    rec_read_len = it.read_length_in;
                    rec_bases_left = (64'(rec_read_len) < ARS_MAX_READ_LENGTH)
                        ? rec_read_len : 16'(ARS_MAX_READ_LENGTH);
                end
            end
            OP_CIGAR: begin
                if (rec_status[ST_MAPPED] && (it.cigar_word[3:0] == CIG_INS
                        || it.cigar_word[3:0] == CIG_DEL)) begin
                    seg_len = it.cigar_word[31:4];
                    if (rec_indels != 16'hFFFF) rec_indels++;
                    sum = {1'b0, rec_indel_len} + 33'(seg_len);
                    rec_indel_len = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            OP_SEQ: begin
                if (rec_status[ST_MAPPED]) begin
                    count_nibble(it.seq_byte[7:4]);
                    count_nibble(it.seq_byte[3:0]);
                end
            end
            default: ;
        endcase
        if (it.last) begin
            emits = 1'b1;
            res.status_bits   = rec_status;
            res.edit_distance = rec_edit;
            res.indel_count   = rec_indels;
            res.indel_length  = rec_indel_len;
            res.map_quality   = rec_quality;
            res.insert_size   = rec_insert;
            res.read_length   = rec_read_len;
            res.count_a       = rec_bases[0];
            res.count_c       = rec_bases[1];
            res.count_g       = rec_bases[2];
            res.count_t       = rec_bases[3];
            res.count_n       = rec_bases[4];
            clear_record();
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    task automatic compare_stats(input t_out_item want, input t_out_item got);
        check_field("status_bits",   32'(want.status_bits),   32'(got.status_bits));
        check_field("edit_distance", 32'(want.edit_distance), 32'(got.edit_distance));
        check_field("indel_count",   32'(want.indel_count),   32'(got.indel_count));
        check_field("indel_length",  want.indel_length,       got.indel_length);
        check_field("map_quality",   32'(want.map_quality),   32'(got.map_quality));
        check_field("insert_size",   want.insert_size,        got.insert_size);
        check_field("read_length",   32'(want.read_length),   32'(got.read_length));
        check_field("count_a",       32'(want.count_a),       32'(got.count_a));
        check_field("count_c",       32'(want.count_c),       32'(got.count_c));
        check_field("count_g",       32'(want.count_g),       32'(got.count_g));
        check_field("count_t",       32'(want.count_t),       32'(got.count_t));
        check_field("count_n",       32'(want.count_n),       32'(got.count_n));
    endtask

    always @(posedge i_clk) begin
        bit        emits;
        t_out_item res;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_stats(i_in_data, emits, res);
                if (emits) expected_stats.push_back(drv_typed ? drv_want : res);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_stats.pop_front();
                    compare_stats(want, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_in_item noise_item(input logic [1:0] op, input logic last);
        logic [159:0] r;
        t_in_item     it;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = r[$bits(t_in_item)-1:0];
        it.opcode = op;
        it.last = last;
        return it;
    endfunction

    function automatic t_in_item hdr_item(input logic [15:0] fl, input logic [7:0] mq,
                                          input logic [31:0] tl, input logic [15:0] nm,
                                          input logic [15:0] rl, input logic last);
        t_in_item it;
        it = noise_item(OP_HEADER, last);
        it.flags = fl;
        it.map_quality_in = mq;
        it.template_length = tl;
        it.edit_distance_in = nm;
        it.read_length_in = rl;
        return it;
    endfunction

    function automatic t_in_item cig_item(input logic [31:0] word, input logic last);
        t_in_item it;
        it = noise_item(OP_CIGAR, last);
        it.cigar_word = word;
        return it;
    endfunction

    function automatic t_in_item seq_item(input logic [7:0] b, input logic last);
        t_in_item it;
        it = noise_item(OP_SEQ, last);
        it.seq_byte = b;
        return it;
    endfunction

    function automatic logic [3:0] rand_base();
        case ($urandom_range(0, 5))
            0:       return BASE_A;
            1:       return BASE_C;
            2:       return BASE_G;
            3:       return BASE_T;
            4:       return BASE_N;
            default: return 4'($urandom);
        endcase
    endfunction

    task automatic add_row(input t_in_item it, input bit typed, input t_out_item want);
        t_row row;
        row.it = it;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic push_item(input t_in_item it, input bit typed, input t_out_item want);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        drv_typed <= typed;
        drv_want <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // hold the sender until every pending record has reported
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_record();
        t_in_item    rec [$];
        logic [15:0] fl;
        logic [15:0] rl;
        logic [3:0]  op;
        logic [27:0] seg_len;
        int          n_cig;
        int          n_seq;
        int          style;
        int          pos;
        style = $urandom_range(0, 9);
        fl = 16'($urandom);
        if ($urandom_range(0, 4) != 0) fl[FL_UNMAP] = 1'b0;
        if ($urandom_range(0, 1) != 0) fl = (fl | FM_PAIRED | FM_PROPER) & ~FM_MUNMAP;
        rl = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 24)) : 16'($urandom);
        rec.push_back(hdr_item(fl, 8'($urandom), $urandom, 16'($urandom), rl, 1'b0));
        n_cig = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 5);
        for (int k = 0; k < n_cig; k++) begin
            if ($urandom_range(0, 2) == 0) op = 4'($urandom);
            else op = ($urandom_range(0, 1) != 0) ? CIG_INS : CIG_DEL;
            seg_len = ($urandom_range(0, 3) == 0) ? 28'($urandom) : 28'($urandom_range(0, 50));
            rec.push_back(cig_item({seg_len, op}, 1'b0));
        end
        n_seq = $urandom_range(0, (rl > 28) ? 16 : rl / 2 + 2);
        for (int k = 0; k < n_seq; k++) rec.push_back(seq_item({rand_base(), rand_base()}, 1'b0));
        // a few broken records: no header, a no-op inside, a restart, an early end
        case (style)
            0: void'(rec.pop_front());
            1: rec.insert($urandom_range(0, rec.size()), noise_item(OP_NOP, 1'b0));
            2: rec.insert($urandom_range(1, rec.size()),
                          hdr_item(16'($urandom), 8'($urandom), $urandom, 16'($urandom),
                                   16'($urandom_range(0, 20)), 1'b0));
            3: begin
                pos = $urandom_range(0, rec.size() - 1);
                rec[pos].last = 1'b1;
            end
            default: ;
        endcase
        if (rec.size() == 0) rec.push_back(noise_item(OP_NOP, 1'b0));
        rec[rec.size() - 1].last = 1'b1;
        foreach (rec[k]) push_item(rec[k], 1'b0, '0);
    endtask

    task automatic run_random_phase();
        items_sent = 0;
        while (items_sent < PHASE_ITEMS) begin
            send_random_record();
            if ($urandom_range(0, 29) == 0) wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial begin
        t_out_item ext_want;
        clear_record();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed records
        ext_want = '0;
        ext_want.status_bits = (6'h1 << ST_MAPPED) | (6'h1 << ST_PRIMARY) | (6'h1 << ST_MATE2);
        ext_want.edit_distance = 16'hFFFF;
        ext_want.map_quality = 8'hFF;
        ext_want.insert_size = 32'h8000_0000;

        // transactions with no open record
        add_row(seq_item({BASE_A, BASE_A}, 1'b1), 1'b1, '0);
        add_row(cig_item({28'd1, CIG_INS}, 1'b1), 1'b0, '0);
        add_row(noise_item(OP_NOP, 1'b1), 1'b1, '0);
        // unmapped record ignores its body
        add_row(hdr_item(FM_UNMAP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0), 1'b0, '0);
        add_row(cig_item({28'd5, CIG_INS}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_A, BASE_C}, 1'b1), 1'b1, '0);
        // extremes: most negative template length, header ends the record
        add_row(hdr_item(FM_PAIRED | FM_PROPER, 8'hFF, 32'h8000_0000, 16'hFFFF, 16'd0, 1'b1),
                1'b1, ext_want);
        // full record, counted and ignored cigar and base codes, one nibble past the read
        add_row(hdr_item(FM_PAIRED | FM_REVERSE | FM_READ1, 8'd60, 32'd300, 16'd3, 16'd7, 1'b0),
                1'b0, '0);
        add_row(cig_item({28'd100, CIG_INS}, 1'b0), 1'b0, '0);
        add_row(cig_item({28'hFFF_FFFF, CIG_DEL}, 1'b0), 1'b0, '0);
        add_row(cig_item({28'd7, 4'd0}, 1'b0), 1'b0, '0);
        add_row(cig_item(32'hFFFF_FFFF, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_A, BASE_C}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_G, BASE_T}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_N, 4'd3}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_A, BASE_A}, 1'b1), 1'b0, '0);
        // header restart inside a record, secondary, mate unmapped
        add_row(hdr_item(~FM_UNMAP, 8'd0, 32'd0, 16'd0, 16'd2, 1'b0), 1'b0, '0);
        add_row(hdr_item(FM_PAIRED | FM_PROPER | FM_SECONDARY, 8'd1, 32'h7FFF_FFFF, 16'd1,
                         16'd3, 1'b0), 1'b0, '0);
        add_row(cig_item({28'd3, CIG_DEL}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_C, BASE_C}, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_G, BASE_T}, 1'b1), 1'b0, '0);
        // single end keeps no insert size
        add_row(hdr_item(16'h0000, 8'd9, -32'sd5, 16'd0, 16'd1, 1'b1), 1'b0, '0);
        // no-op inside a record, zero read length
        add_row(hdr_item(FM_PAIRED | FM_PROPER | FM_REVERSE, 8'd7, -32'sd5, 16'd2, 16'd0, 1'b0),
                1'b0, '0);
        add_row(noise_item(OP_NOP, 1'b0), 1'b0, '0);
        add_row(seq_item({BASE_A, BASE_T}, 1'b1), 1'b0, '0);

        send_idle = 9;
        recv_idle = 81;
        foreach (directed_rows[k])
            push_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
        wait_results_drained();

        run_random_phase();
        send_idle = 81;
        recv_idle = 9;
        run_random_phase();
        send_idle = 0;
        recv_idle = 0;
        run_random_phase();

        // indel length saturates within one record
        push_item(hdr_item(FM_PAIRED | FM_READ1, 8'd42, 32'd0, 16'd9, 16'd0, 1'b0), 1'b0, '0);
        for (int k = 0; k < 20; k++)
            push_item(cig_item({28'hFFF_FFFF, (k % 2 == 0) ? CIG_INS : CIG_DEL}, k == 19),
                      1'b0, '0);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_stats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ars_pkg.sv
src/ars_in_reg.sv
src/ars_hdr_dec.sv
src/ars_accum.sv
src/alignment_record_stats.sv
src/ars_checker.sv
dv/alignment_record_stats_tb.sv
